// ===== rtl/core/rc5_pkg.sv =====
package rc5_pkg;

  localparam int unsigned ROUND_COUNT = 8;
  localparam int unsigned KEY_WORDS   = 2 * ROUND_COUNT + 2;
  localparam int unsigned WORD_W      = 16;
  localparam int unsigned IDX_W       = 5;
  localparam int unsigned CNT_W       = $clog2(ROUND_COUNT + 1);

  typedef enum logic [1:0] {
    REQ_ENC = 2'd0,
    REQ_DEC = 2'd1,
    REQ_KEY = 2'd2
  } req_e;

  typedef struct packed {
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] a;
  } blk_t;

  typedef struct packed {
    logic              we;
    logic              hi;
    logic [WORD_W-1:0] word;
  } key_wr_t;

  function automatic logic [WORD_W-1:0] rotl16(logic [WORD_W-1:0] v, logic [3:0] s);
    logic [2*WORD_W-1:0] t;
    t = {v, v} << s;
    return t[2*WORD_W-1:WORD_W];
  endfunction

  function automatic logic [WORD_W-1:0] rotr16(logic [WORD_W-1:0] v, logic [3:0] s);
    logic [2*WORD_W-1:0] t;
    t = {v, v} >> s;
    return t[WORD_W-1:0];
  endfunction

  // expanded subkeys loaded at reset, zero past the stock 18 words
  function automatic logic [WORD_W-1:0] init_key(int unsigned i);
    logic [WORD_W-1:0] k;
    case (i)
      0:       k = 16'hB7E1;
      1:       k = 16'h5618;
      2:       k = 16'hF44F;
      3:       k = 16'h9286;
      4:       k = 16'h30BD;
      5:       k = 16'hCEF4;
      6:       k = 16'h6D2B;
      7:       k = 16'h0B62;
      8:       k = 16'hA999;
      9:       k = 16'h47D0;
      10:      k = 16'hE607;
      11:      k = 16'h843E;
      12:      k = 16'h2275;
      13:      k = 16'hC0AC;
      14:      k = 16'h5EE3;
      15:      k = 16'hFD1A;
      16:      k = 16'h9B51;
      17:      k = 16'h3988;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/core/rc5_16_block_cipher.sv =====
// channel   dir  signals                          content
// s_axis    in   tvalid tready tuser[1:0]       tuser req_type, tdata see port
//                tdata[55:0]
// m_axis    out  tvalid tready tdata[31:0]      out_a, out_b
//
// encrypt and decrypt carry the block from in_q through the round cells into out_q
// one round cell per round, the block moves one cell per cycle, left to right
// for encrypt and right to left for decrypt
// subkey writes take effect at the transfer; rst_ni reloads the stock subkeys
// a waiting result is held in the output register; a finished block stalls
// the chain until that register frees up, and no item is taken while one runs
module rc5_16_block_cipher
  import rc5_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,  // req_type
  input  logic [55:0] s_axis_tdata,  // key_index[4:0], key_word, word_a, word_b, zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // out_a, out_b
);

  logic              in_fire;
  req_e              req;
  logic [IDX_W-1:0]  key_idx;
  logic [WORD_W-1:0] key_word;
  logic              key_ok;
  logic              start;

  logic              run_q, dec_q, out_vld_q;
  logic [CNT_W-1:0]  cnt_q;
  blk_t              in_q, out_q;
  logic              finish, en;

  blk_t              whitened, unwhitened;
  blk_t              cell_out [1:ROUND_COUNT];
  key_wr_t           edge_wr;

  assign s_axis_tready = !run_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign req           = req_e'(s_axis_tuser);
  assign key_idx       = s_axis_tdata[IDX_W-1:0];
  assign key_word      = s_axis_tdata[IDX_W +: WORD_W];
  assign key_ok        = in_fire && (req == REQ_KEY) && (32'(key_idx) < KEY_WORDS);

  always_comb begin
    case (req)
      REQ_ENC: start = in_fire;
      REQ_DEC: start = in_fire;
      default: start = 1'b0;
    endcase
  end

  assign finish = run_q && (cnt_q == CNT_W'(ROUND_COUNT));
  assign en     = !finish || !out_vld_q || m_axis_tready;

  assign edge_wr.we   = key_ok && (key_idx[IDX_W-1:1] == '0);
  assign edge_wr.hi   = key_idx[0];
  assign edge_wr.word = key_word;

  rc5_edge u_edge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .key_wr_i   (edge_wr),
    .whiten_i   (in_q),
    .unwhiten_i (cell_out[1]),
    .whiten_o   (whitened),
    .unwhiten_o (unwhitened)
  );

  for (genvar k = 1; k <= ROUND_COUNT; k++) begin : g_cell
    key_wr_t wr;
    blk_t    enc_in, dec_in;

    assign wr.we   = key_ok && (key_idx[IDX_W-1:1] == (IDX_W-1)'(k));
    assign wr.hi   = key_idx[0];
    assign wr.word = key_word;

    if (k == 1) begin : g_first
      assign enc_in = whitened;
    end else begin : g_mid
      assign enc_in = cell_out[k-1];
    end

    if (k == ROUND_COUNT) begin : g_last
      assign dec_in = in_q;
    end else begin : g_inner
      assign dec_in = cell_out[k+1];
    end

    rc5_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .dec_i     (dec_q),
      .key_wr_i  (wr),
      .init_a_i  (init_key(2 * k)),
      .init_b_i  (init_key(2 * k + 1)),
      .enc_i     (enc_in),
      .dec_blk_i (dec_in),
      .blk_o     (cell_out[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q     <= 1'b0;
      dec_q     <= 1'b0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (finish && en) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      if (start) begin
        run_q <= 1'b1;
        dec_q <= (req == REQ_DEC);
        cnt_q <= '0;
      end else if (run_q && en) begin
        if (finish) begin
          run_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      in_q.a <= s_axis_tdata[IDX_W+WORD_W +: WORD_W];
      in_q.b <= s_axis_tdata[IDX_W+2*WORD_W +: WORD_W];
    end
    if (finish && en) begin
      out_q <= dec_q ? unwhitened : cell_out[ROUND_COUNT];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q.b, out_q.a};

endmodule

// ===== rtl/core/rc5_cell.sv =====
module rc5_cell
  import rc5_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              dec_i,
  input  key_wr_t           key_wr_i,
  input  logic [WORD_W-1:0] init_a_i,
  input  logic [WORD_W-1:0] init_b_i,
  input  blk_t              enc_i,
  input  blk_t              dec_blk_i,
  output blk_t              blk_o
);

  logic [WORD_W-1:0] key_a_q, key_b_q;
  blk_t              blk_q, blk_d;
  blk_t              enc_r, dec_r;
  logic [WORD_W-1:0] dec_b_sub, dec_a_sub;

  always_comb begin
    enc_r.a   = rotl16(enc_i.a ^ enc_i.b, enc_i.b[3:0]) + key_a_q;
    enc_r.b   = rotl16(enc_i.b ^ enc_r.a, enc_r.a[3:0]) + key_b_q;
    dec_b_sub = dec_blk_i.b - key_b_q;
    dec_r.b   = rotr16(dec_b_sub, dec_blk_i.a[3:0]) ^ dec_blk_i.a;
    dec_a_sub = dec_blk_i.a - key_a_q;
    dec_r.a   = rotr16(dec_a_sub, dec_r.b[3:0]) ^ dec_r.b;
    blk_d     = dec_i ? dec_r : enc_r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_a_q <= init_a_i;
      key_b_q <= init_b_i;
    end else if (key_wr_i.we) begin
      if (key_wr_i.hi) begin
        key_b_q <= key_wr_i.word;
      end else begin
        key_a_q <= key_wr_i.word;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      blk_q <= blk_d;
    end
  end

  assign blk_o = blk_q;

endmodule

// ===== rtl/core/rc5_edge.sv =====
module rc5_edge
  import rc5_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  key_wr_t key_wr_i,
  input  blk_t    whiten_i,
  input  blk_t    unwhiten_i,
  output blk_t    whiten_o,
  output blk_t    unwhiten_o
);

  logic [WORD_W-1:0] key_a_q, key_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_a_q <= init_key(0);
      key_b_q <= init_key(1);
    end else if (key_wr_i.we) begin
      if (key_wr_i.hi) begin
        key_b_q <= key_wr_i.word;
      end else begin
        key_a_q <= key_wr_i.word;
      end
    end
  end

  always_comb begin
    whiten_o.a   = whiten_i.a + key_a_q;
    whiten_o.b   = whiten_i.b + key_b_q;
    unwhiten_o.a = unwhiten_i.a - key_a_q;
    unwhiten_o.b = unwhiten_i.b - key_b_q;
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import rc5_pkg::*;

  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam int unsigned STALL_LIMIT = 2000;

  localparam logic [WORD_W-1:0] STOCK_KEYS [18] = '{
    16'hB7E1, 16'h5618, 16'hF44F, 16'h9286, 16'h30BD, 16'hCEF4,
    16'h6D2B, 16'h0B62, 16'hA999, 16'h47D0, 16'hE607, 16'h843E,
    16'h2275, 16'hC0AC, 16'h5EE3, 16'hFD1A, 16'h9B51, 16'h3988
  };

  typedef struct {
    logic [1:0]        kind;
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] kword;
    logic [WORD_W-1:0] wa;
    logic [WORD_W-1:0] wb;
  } request_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [1:0]  s_axis_tuser;   // req_type
  logic [55:0] s_axis_tdata;   // key_index[4:0], key_word, word_a, word_b, zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // out_a, out_b

  logic [WORD_W-1:0] subkeys [KEY_WORDS];
  blk_t              blocks_q [$];
  int                mismatches;
  int                burst_left;
  int unsigned       idle_cycles;

  rc5_16_block_cipher DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [WORD_W-1:0] rol16(logic [WORD_W-1:0] v, logic [3:0] s);
    logic [2*WORD_W-1:0] w;
    w = {16'h0000, v} << s;
    return w[WORD_W-1:0] | w[2*WORD_W-1:WORD_W];
  endfunction

  function automatic logic [WORD_W-1:0] ror16(logic [WORD_W-1:0] v, logic [3:0] s);
    logic [2*WORD_W-1:0] w;
    w = {v, 16'h0000} >> s;
    return w[WORD_W-1:0] | w[2*WORD_W-1:WORD_W];
  endfunction

  function automatic blk_t encrypt_block(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
    blk_t res;
    a = a + subkeys[0];
    b = b + subkeys[1];
    for (int r = 1; r <= ROUND_COUNT; r++) begin
      a = rol16(a ^ b, b[3:0]) + subkeys[2*r];
      b = rol16(b ^ a, a[3:0]) + subkeys[2*r+1];
    end
    res.a = a;
    res.b = b;
    return res;
  endfunction

  function automatic blk_t decrypt_block(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
    blk_t res;
    for (int r = ROUND_COUNT; r > 0; r--) begin
      b = ror16(b - subkeys[2*r+1], a[3:0]) ^ a;
      a = ror16(a - subkeys[2*r], b[3:0]) ^ b;
    end
    res.b = b - subkeys[1];
    res.a = a - subkeys[0];
    return res;
  endfunction

  function automatic request_t make_req(logic [1:0] kind, logic [IDX_W-1:0] idx,
                                        logic [WORD_W-1:0] kword,
                                        logic [WORD_W-1:0] wa, logic [WORD_W-1:0] wb);
    request_t rq;
    rq.kind  = kind;
    rq.idx   = idx;
    rq.kword = kword;
    rq.wa    = wa;
    rq.wb    = wb;
    return rq;
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return WORD_W'($urandom);
    endcase
  endfunction

  // update the subkey copy and queue the expected block at the transfer
  function automatic void apply_request(request_t rq);
    case (rq.kind)
      REQ_ENC: blocks_q.push_back(encrypt_block(rq.wa, rq.wb));
      REQ_DEC: blocks_q.push_back(decrypt_block(rq.wa, rq.wb));
      REQ_KEY: if (rq.idx < KEY_WORDS) subkeys[rq.idx] = rq.kword;
      default: ;
    endcase
  endfunction

  task automatic send_request(request_t rq);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= rq.kind;
    s_axis_tdata  <= {3'b000, rq.wb, rq.wa, rq.kword, rq.idx};
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    apply_request(rq);
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (blocks_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_stock_vectors();
    send_request(make_req(REQ_ENC, 5'd0, 16'h0000, 16'h0000, 16'h0000));
    send_request(make_req(REQ_ENC, 5'd0, 16'h0000, 16'hFFFF, 16'hFFFF));
    send_request(make_req(REQ_ENC, 5'd31, 16'hFFFF, 16'h0000, 16'hFFFF));
    send_request(make_req(REQ_ENC, 5'd17, 16'hA5A5, 16'h8000, 16'h0001));
    send_request(make_req(REQ_DEC, 5'd0, 16'h0000, 16'h0000, 16'h0000));
    send_request(make_req(REQ_DEC, 5'd31, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_request(make_req(REQ_DEC, 5'd9, 16'h5A5A, 16'h1234, 16'hABCD));
  endtask

  task automatic test_key_writes();
    send_request(make_req(REQ_KEY, 5'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_request(make_req(REQ_KEY, 5'd17, 16'h0000, 16'h1234, 16'h5678));
    // out of range indexes leave the table alone
    send_request(make_req(REQ_KEY, 5'd18, 16'h1234, 16'h0000, 16'h0000));
    send_request(make_req(REQ_KEY, 5'd31, 16'hFFFF, 16'h0000, 16'h0000));
    // unused request type
    send_request(make_req(REQ_NONE, 5'd31, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_request(make_req(REQ_ENC, 5'd0, 16'h0000, 16'h0000, 16'h0000));
    send_request(make_req(REQ_DEC, 5'd0, 16'h0000, 16'hFFFF, 16'h0000));
    send_request(make_req(REQ_KEY, 5'd16, 16'h8001, 16'h0000, 16'h0000));
    send_request(make_req(REQ_ENC, 5'd3, 16'h0000, 16'h5A5A, 16'hA5A5));
    send_request(make_req(REQ_DEC, 5'd3, 16'h0000, 16'h5A5A, 16'hA5A5));
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 6; i++)
      send_request(make_req(REQ_ENC, IDX_W'($urandom), rand_word(), rand_word(), rand_word()));
    wait_for_results();
    send_request(make_req(REQ_DEC, 5'd0, 16'h0000, rand_word(), rand_word()));
  endtask

  task automatic test_random_traffic(int target);
    int       sent;
    int       sel;
    blk_t     ct;
    request_t rq;
    sent = 0;
    while (sent < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        rq = make_req(REQ_KEY, IDX_W'($urandom_range(0, KEY_WORDS - 1)), rand_word(),
                      rand_word(), rand_word());
        send_request(rq);
        sent++;
      end else if (sel < 10) begin
        rq = make_req(REQ_KEY, IDX_W'($urandom_range(KEY_WORDS, 31)), rand_word(),
                      rand_word(), rand_word());
        send_request(rq);
        sent++;
      end else if (sel < 13) begin
        send_request(make_req(REQ_NONE, IDX_W'($urandom), rand_word(), rand_word(),
                              rand_word()));
      end else if (sel < 45) begin
        send_request(make_req(REQ_ENC, IDX_W'($urandom), rand_word(), rand_word(),
                              rand_word()));
        sent++;
      end else if (sel < 75) begin
        send_request(make_req(REQ_DEC, IDX_W'($urandom), rand_word(), rand_word(),
                              rand_word()));
        sent++;
      end else begin
        // round trip: decrypt the ciphertext just produced
        rq = make_req(REQ_ENC, IDX_W'($urandom), rand_word(), rand_word(), rand_word());
        ct = encrypt_block(rq.wa, rq.wb);
        send_request(rq);
        send_request(make_req(REQ_DEC, IDX_W'($urandom), rand_word(), ct.a, ct.b));
        sent += 2;
      end
    end
  endtask

  // receiver stall pattern
  initial begin
    int stall_mode;
    int phase_left;
    int hold;
    logic level;
    stall_mode    = 0;
    phase_left    = 0;
    hold          = 0;
    level         = 1'b1;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (phase_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        phase_left = $urandom_range(20, 120);
      end
      phase_left--;
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        default: begin
          if (hold == 0) begin
            level = ~level;
            hold  = level ? $urandom_range(1, 6) : $urandom_range(1, 24);
          end
          hold--;
          m_axis_tready <= level;
        end
      endcase
    end
  end

  always @(posedge clk_i) begin : check_results
    blk_t want;
    blk_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (blocks_q.size() == 0) begin
        $error("unexpected result out_a=%h out_b=%h", got.a, got.b);
        mismatches++;
      end else begin
        want = blocks_q.pop_front();
        if (got.a !== want.a) begin
          $error("out_a expected %h actual %h", want.a, got.a);
          mismatches++;
        end
        if (got.b !== want.b) begin
          $error("out_b expected %h actual %h", want.b, got.b);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("rc5_16_block_cipher: mismatch");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < KEY_WORDS; i++) subkeys[i] = (i < 18) ? STOCK_KEYS[i] : '0;
    mismatches    = 0;
    burst_left    = 0;
    idle_cycles   = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = '0;
    s_axis_tdata  = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_stock_vectors();
    test_key_writes();
    test_drain_pause();
    test_random_traffic(1850);

    wait_for_results();
    repeat (ROUND_COUNT + 12) @(posedge clk_i);
    if (mismatches == 0 && blocks_q.size() == 0) begin
      $display("rc5_16_block_cipher: match");
    end else begin
      $display("rc5_16_block_cipher: mismatch");
    end
    $finish;
  end

endmodule
